>>> rtl/core/stlp_pkg.sv
// Shared types and constants of the binary STL triangle parser.
package stlp_pkg;

    localparam int unsigned PosWidth = 7;
    localparam int unsigned WordWidth = 32;

    localparam logic [PosWidth-1:0] HeaderLastPos = PosWidth'(80 - 1);
    localparam logic [PosWidth-1:0] CountLastPos = PosWidth'(84 - 80 - 1);
    localparam logic [PosWidth-1:0] RecordLastPos = PosWidth'(50 - 1);
    localparam logic [3:0] VectorLastOff = 4'(12 - 1);
    localparam logic [3:0] FirstWordLastOff = 4'd3;
    localparam logic [3:0] SecondWordLastOff = 4'd7;
    localparam logic [2:0] LastVertexVec = 3'd3;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_NORMAL = 2'd1,
        KIND_VERTEX = 2'd2
    } stlp_kind_t;

    typedef struct packed {
        logic                 valid;
        stlp_kind_t           kind;
        logic [7:0]           header_byte;
        logic [WordWidth-1:0] x_bits;
        logic [WordWidth-1:0] y_bits;
        logic [WordWidth-1:0] z_bits;
        logic [WordWidth-1:0] vertex_index;
        logic                 last;
    } stlp_result_t;

endpackage

>>> rtl/core/binary_stl_triangle_parser.sv
// Top level of the binary STL triangle parser: input register, parser, result register.
//
//  Channel  Direction  Word                          Side band
//  s_axis   in         tdata: data_byte              tuser: start_of_file
//  m_axis   out        tdata: header, x, y, z, index tuser: kind, tlast: last
//
// One byte is taken per cycle while the result register is not stalled; a byte passes
// the input register, is decoded against the parser state and, if it makes a word, lands in the
// result register, from which the word is presented.
// Reset clears the parser to the header phase at byte zero and empties both registers.
// A stalled result register holds its word; input keeps flowing while it is free
// or being taken in the same cycle.
module binary_stl_triangle_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic         s_axis_tuser,  // [0] start_of_file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] header_byte, [39:8] x_bits, [71:40] y_bits, [103:72] z_bits,
    // [135:104] vertex_index
    output logic [135:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // [1:0] kind
    output logic         m_axis_tlast
);
    import stlp_pkg::*;

    logic         in_valid_reg;
    logic         in_sof_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg, out_valid_next;
    stlp_result_t out_reg;
    stlp_result_t result;
    logic         step;

    assign step = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    stlp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .start_of_file (in_sof_reg),
        .data_byte     (in_byte_reg),
        .result        (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = result.valid;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_sof_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
        if (step && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {out_reg.vertex_index, out_reg.z_bits, out_reg.y_bits,
                           out_reg.x_bits, out_reg.header_byte};
    assign m_axis_tuser = out_reg.kind;
    assign m_axis_tlast = out_reg.last;

    a_last_is_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_VERTEX)
        else $error("last flag on a word that is not a vertex");

    a_header_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_HEADER |-> m_axis_tdata[135:8] == '0)
        else $error("header word carries vector or index bits");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result word present right after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_axis_tready)
        else $error("input refused while the input register is empty");

endmodule

>>> rtl/core/stlp_parser.sv
// Parser state and per-byte decode of the binary STL stream.
module stlp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  start_of_file,
    input  logic [7:0]            data_byte,
    output stlp_pkg::stlp_result_t result
);
    import stlp_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_COUNT   = 2'd1,
        PH_RECORDS = 2'd2,
        PH_DONE    = 2'd3
    } stlp_phase_t;

    stlp_phase_t          phase_reg, phase_next, phase_cur;
    logic [PosWidth-1:0]  pos_reg, pos_next, pos_cur;
    logic [2:0]           vec_reg, vec_next;
    logic [3:0]           off_reg, off_next;
    logic [WordWidth-1:0] acc_reg, acc_next, acc_cur;
    logic [WordWidth-1:0] first_reg, first_next;
    logic [WordWidth-1:0] second_reg, second_next;
    logic [WordWidth-1:0] total_reg, total_next;
    logic [WordWidth-1:0] done_reg, done_next;
    logic [WordWidth-1:0] vidx_reg, vidx_next;
    logic [WordWidth-1:0] done_plus1;
    logic                 in_vectors;

    always_comb begin
        phase_cur = start_of_file ? PH_HEADER : phase_reg;
        pos_cur = start_of_file ? '0 : pos_reg;
        acc_cur = start_of_file ? '0 : acc_reg;
        acc_next = {data_byte, acc_cur[WordWidth-1:8]};
        done_plus1 = done_reg + WordWidth'(1);
        in_vectors = !vec_reg[2];

        phase_next = phase_cur;
        pos_next = pos_cur;
        vec_next = vec_reg;
        off_next = off_reg;
        first_next = first_reg;
        second_next = second_reg;
        total_next = total_reg;
        done_next = done_reg;
        vidx_next = vidx_reg;
        result = '0;

        case (phase_cur)
            PH_HEADER: begin
                result.valid = 1'b1;
                result.kind = KIND_HEADER;
                result.header_byte = data_byte;
                pos_next = pos_cur + PosWidth'(1);
                if (pos_cur == HeaderLastPos) begin
                    pos_next = '0;
                    phase_next = PH_COUNT;
                end
            end
            PH_COUNT: begin
                pos_next = pos_cur + PosWidth'(1);
                if (pos_cur == CountLastPos) begin
                    pos_next = '0;
                    vec_next = '0;
                    off_next = '0;
                    done_next = '0;
                    vidx_next = '0;
                    // A count of zero or less leaves no records to parse.
                    if (acc_next == '0 || acc_next[WordWidth-1]) begin
                        total_next = '0;
                        phase_next = PH_DONE;
                    end else begin
                        total_next = acc_next;
                        phase_next = PH_RECORDS;
                    end
                end
            end
            PH_RECORDS: begin
                if (in_vectors) begin
                    off_next = off_reg + 4'd1;
                    if (off_reg == FirstWordLastOff) begin
                        first_next = acc_next;
                    end else if (off_reg == SecondWordLastOff) begin
                        second_next = acc_next;
                    end else if (off_reg == VectorLastOff) begin
                        off_next = '0;
                        vec_next = vec_reg + 3'd1;
                        result.valid = 1'b1;
                        result.x_bits = first_reg;
                        result.y_bits = acc_next;
                        result.z_bits = second_reg;
                        if (vec_reg == '0) begin
                            result.kind = KIND_NORMAL;
                        end else begin
                            result.kind = KIND_VERTEX;
                            result.vertex_index = vidx_reg;
                            vidx_next = vidx_reg + WordWidth'(1);
                            result.last = (vec_reg == LastVertexVec) &&
                                          (done_plus1 == total_reg);
                        end
                    end
                end
                pos_next = pos_cur + PosWidth'(1);
                if (pos_cur == RecordLastPos) begin
                    pos_next = '0;
                    vec_next = '0;
                    off_next = '0;
                    done_next = done_plus1;
                    if (done_plus1 == total_reg) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg <= '0;
            vec_reg <= '0;
            off_reg <= '0;
            acc_reg <= '0;
            first_reg <= '0;
            second_reg <= '0;
            total_reg <= '0;
            done_reg <= '0;
            vidx_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            vec_reg <= vec_next;
            off_reg <= off_next;
            acc_reg <= acc_next;
            first_reg <= first_next;
            second_reg <= second_next;
            total_reg <= total_next;
            done_reg <= done_next;
            vidx_reg <= vidx_next;
        end
    end

endmodule

>>> sim/tb_binary_stl_triangle_parser.sv
// Self-checking testbench of the binary STL triangle parser with a byte-level predictor.
module tb_binary_stl_triangle_parser;
    import stlp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned HeaderBytes = 80;
    localparam int unsigned CountBytes = 4;
    localparam int unsigned RecordBytes = 50;
    localparam int unsigned VectorBytes = 12;
    localparam int unsigned VectorBytesPerRecord = 48;
    localparam int unsigned RandomBytes = 640;
    localparam int unsigned MaxReported = 10;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_COUNT   = 2'd1,
        PH_RECORDS = 2'd2,
        PH_DONE    = 2'd3
    } parse_phase_t;

    typedef struct packed {
        stlp_kind_t  kind;
        logic [7:0]  header_byte;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
        logic [31:0] vertex_index;
        logic        last;
    } stl_word_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    parse_phase_t phase;
    int unsigned  byte_pos;
    logic [31:0]  tri_total;
    logic [31:0]  tri_done;
    logic [31:0]  word_acc;
    logic [31:0]  first_word;
    logic [31:0]  second_word;
    logic [31:0]  next_vertex;

    stl_word_t    expected_words[$];
    logic [7:0]   file_bytes[$];
    int unsigned  items_sent;
    int unsigned  mismatches;
    int unsigned  cycle_count;
    logic         idle_on;

    binary_stl_triangle_parser u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic clear_parse_state();
        phase = PH_HEADER;
        byte_pos = 0;
        tri_total = '0;
        tri_done = '0;
        word_acc = '0;
        first_word = '0;
        second_word = '0;
        next_vertex = '0;
    endtask

    task automatic append_file_byte(input logic [7:0] b);
        file_bytes = {file_bytes, b};
    endtask

    // Works out the word, if any, that one accepted byte produces.
    task automatic predict_stl_byte(input logic sof, input logic [7:0] b);
        stl_word_t   w;
        logic        emit;
        int unsigned vec;
        int unsigned off;
        if (sof) begin
            clear_parse_state();
        end
        w = '0;
        emit = 1'b0;
        word_acc = {b, word_acc[31:8]};
        case (phase)
            PH_HEADER: begin
                w.kind = KIND_HEADER;
                w.header_byte = b;
                emit = 1'b1;
                byte_pos++;
                if (byte_pos >= HeaderBytes) begin
                    byte_pos = 0;
                    phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                byte_pos++;
                if (byte_pos >= CountBytes) begin
                    byte_pos = 0;
                    tri_done = '0;
                    next_vertex = '0;
                    if (word_acc == '0 || word_acc[31]) begin
                        tri_total = '0;
                        phase = PH_DONE;
                    end else begin
                        tri_total = word_acc;
                        phase = PH_RECORDS;
                    end
                end
            end
            PH_RECORDS: begin
                if (byte_pos < VectorBytesPerRecord) begin
                    vec = byte_pos / VectorBytes;
                    off = byte_pos % VectorBytes;
                    if (off == 3) begin
                        first_word = word_acc;
                    end else if (off == 7) begin
                        second_word = word_acc;
                    end else if (off == 11) begin
                        w.x_bits = first_word;
                        w.y_bits = word_acc;
                        w.z_bits = second_word;
                        if (vec == 0) begin
                            w.kind = KIND_NORMAL;
                        end else begin
                            w.kind = KIND_VERTEX;
                            w.vertex_index = next_vertex;
                            next_vertex = next_vertex + 32'd1;
                            w.last = (vec == 3) && (tri_done + 32'd1 == tri_total);
                        end
                        emit = 1'b1;
                    end
                end
                byte_pos++;
                if (byte_pos >= RecordBytes) begin
                    byte_pos = 0;
                    tri_done = tri_done + 32'd1;
                    if (tri_done >= tri_total) begin
                        phase = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
        if (emit) begin
            expected_words = {expected_words, w};
        end
    endtask

    task automatic send_byte(input logic sof, input logic [7:0] b);
        while (idle_on && $urandom_range(99) < 35) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata = 8'($urandom);
            s_axis_tuser = 1'($urandom);
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        s_axis_tuser = sof;
        do @(posedge aclk); while (!s_axis_tready);
        predict_stl_byte(sof, b);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            append_file_byte(w[8*i +: 8]);
        end
    endtask

    task automatic add_random_bytes(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            append_file_byte(8'($urandom));
        end
    endtask

    task automatic add_random_record();
        for (int i = 0; i < 12; i++) begin
            case ($urandom_range(7))
                0: add_word(32'h0000_0000);
                1: add_word(32'hFFFF_FFFF);
                default: add_word($urandom);
            endcase
        end
        add_random_bytes(2);
    endtask

    task automatic send_file(input logic sof_first);
        foreach (file_bytes[i]) begin
            send_byte(sof_first && i == 0, file_bytes[i]);
        end
        file_bytes.delete();
    endtask

    task automatic test_no_start_mark();
        append_file_byte(8'h00);
        append_file_byte(8'hFF);
        add_random_bytes(HeaderBytes - 2);
        add_word(32'd1);
        add_word(32'h0000_0000);
        add_word(32'hFFFF_FFFF);
        add_word(32'h8000_0000);
        add_word(32'h3F80_0000);
        add_word(32'h4000_0000);
        add_word(32'h4040_0000);
        add_word(32'h7F80_0000);
        add_word(32'hFF80_0000);
        add_word(32'h7FC0_0000);
        add_word(32'h0000_0001);
        add_word(32'h8000_0001);
        add_word(32'h7FFF_FFFF);
        append_file_byte(8'hFF);
        append_file_byte(8'hFF);
        append_file_byte(8'hAA);
        append_file_byte(8'h55);
        send_file(1'b0);
        add_random_bytes(HeaderBytes);
        add_word(32'd2);
        add_random_record();
        add_random_record();
        send_file(1'b1);
    endtask

    task automatic test_count_not_positive();
        logic [31:0] counts[3];
        counts = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
        foreach (counts[i]) begin
            add_random_bytes(HeaderBytes);
            add_word(counts[i]);
            add_random_bytes(RecordBytes + 10);
            send_file(1'b1);
        end
    endtask

    task automatic test_restart_mid_file();
        add_random_bytes(HeaderBytes);
        add_word(32'd3);
        add_random_record();
        add_random_bytes(30);
        send_file(1'b1);
        add_random_bytes(40);
        send_file(1'b1);
        add_random_bytes(HeaderBytes + 2);
        send_file(1'b1);
        add_random_bytes(HeaderBytes);
        add_word(32'd1);
        add_random_record();
        send_file(1'b1);
    endtask

    task automatic test_random_files();
        int unsigned target;
        int unsigned file_no;
        int unsigned sel;
        int unsigned n_records;
        int unsigned keep;
        logic [31:0] count;
        target = items_sent + RandomBytes;
        file_no = 0;
        while (items_sent < target) begin
            idle_on = !(file_no >= 1 && file_no < 3);
            sel = $urandom_range(99);
            if (sel < 5) begin
                count = '0;
            end else if (sel < 10) begin
                count = {1'b1, 31'($urandom)};
            end else if (sel < 16) begin
                count = {1'b0, 31'($urandom)} | 32'h0100_0000;
            end else begin
                count = $urandom_range(1, 4);
            end
            if (count == '0 || count[31] || count > 32'd4) begin
                n_records = $urandom_range(0, 3);
            end else begin
                n_records = count;
                if ($urandom_range(9) == 0) begin
                    n_records++;
                end
            end
            add_random_bytes(HeaderBytes);
            add_word(count);
            for (int unsigned r = 0; r < n_records; r++) begin
                add_random_record();
            end
            add_random_bytes($urandom_range(0, 4));
            if ($urandom_range(99) < 12) begin
                keep = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > keep) begin
                    void'(file_bytes.pop_back());
                end
            end
            send_file(1'b1);
            file_no++;
        end
        idle_on = 1'b1;
    endtask

    always @(negedge aclk) begin
        m_axis_tready = !idle_on || ($urandom_range(99) >= 35);
    end

    always @(posedge aclk) begin
        stl_word_t act;
        stl_word_t exp_word;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            act.kind = stlp_kind_t'(m_axis_tuser);
            act.header_byte = m_axis_tdata[7:0];
            act.x_bits = m_axis_tdata[39:8];
            act.y_bits = m_axis_tdata[71:40];
            act.z_bits = m_axis_tdata[103:72];
            act.vertex_index = m_axis_tdata[135:104];
            act.last = m_axis_tlast;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReported) begin
                    $display("unexpected word %h", act);
                end
            end else begin
                exp_word = expected_words.pop_front();
                if (act !== exp_word) begin
                    mismatches++;
                    if (mismatches <= MaxReported) begin
                        $display("word mismatch: expected %h, got %h", exp_word, act);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("FAIL binary_stl_triangle_parser");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        idle_on = 1'b1;
        items_sent = 0;
        mismatches = 0;
        cycle_count = 0;
        clear_parse_state();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_no_start_mark();
        test_count_not_positive();
        test_restart_mid_file();
        test_random_files();

        s_axis_tvalid = 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASS binary_stl_triangle_parser");
        end else begin
            $display("FAIL binary_stl_triangle_parser");
        end
        $finish;
    end

endmodule
